// ===== design/abgf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package abgf_pkg;

    localparam int SPEED_FRAC_BITS_DEF = 8;

    localparam int KELVIN_CENTI     = 27315;
    localparam int REF_KELVIN_CENTI = 28815;
    localparam int KI_DIVISOR       = 65536 * 1000;
    localparam int SINCE_MAX        = 131071;

    localparam int ACC_W  = 56;
    localparam int MA_W   = 36;
    localparam int MB_W   = 20;
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 26;
    localparam int DIV_CW = 6;
    localparam int SQ_W   = 34;
    localparam int FAC_W  = 17;
    localparam int SPD_W  = 17;
    localparam int BARO_W = 19;
    localparam int WIDE_W = 58;

    localparam logic [15:0] RST_PERIOD   = 16'd1000;
    localparam logic [15:0] RST_KP       = 16'd655;
    localparam logic [15:0] RST_KI       = 16'd655;
    localparam logic [15:0] RST_GPS_TAU  = 16'd500;
    localparam logic [15:0] RST_BARO_TAU = 16'd1000;
    localparam logic [15:0] RST_HOLD     = 16'd1000;
    localparam logic [10:0] RST_OFFSET   = 11'd500;

    typedef enum logic [2:0] {
        CFG_GPS_ONLY  = 3'd0,
        CFG_PERIOD    = 3'd1,
        CFG_KP        = 3'd2,
        CFG_KI        = 3'd3,
        CFG_GPS_TAU   = 3'd4,
        CFG_BARO_TAU  = 3'd5,
        CFG_HOLD      = 3'd6,
        CFG_OFFSET    = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FAC_DIV,
        ST_FAC_SQRT,
        ST_BARO_MUL,
        ST_BRANCH,
        ST_KI_MUL1,
        ST_KI_MUL2,
        ST_KI_DIV,
        ST_KP_MUL,
        ST_KP_FIN,
        ST_GLP_MUL1,
        ST_GLP_MUL2,
        ST_GLP_DIV,
        ST_CAS_DIV,
        ST_BLP_MUL1,
        ST_BLP_MUL2,
        ST_BLP_DIV,
        ST_OUT
    } state_t;

    function automatic logic signed [SPD_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
        logic signed [SPD_W-1:0] r;
        if (v > WIDE_W'(signed'(65535)))
            r = 17'sh0FFFF;
        else if (v < -WIDE_W'(signed'(65536)))
            r = 17'sh10000;
        else
            r = v[SPD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/abgf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface abgf_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] elapsed_ms;
    logic        [15:0] cas_sensor;
    logic               sensor_present;
    logic signed [14:0] temperature_centi;
    logic               gps_ready;
    logic signed [15:0] gps_speed_in;

    modport source (output valid, elapsed_ms, cas_sensor, sensor_present,
                    temperature_centi, gps_ready, gps_speed_in, input ready);
    modport sink (input valid, elapsed_ms, cas_sensor, sensor_present,
                  temperature_centi, gps_ready, gps_speed_in, output ready);
endinterface
`default_nettype wire

// ===== design/abgf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface abgf_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] true_speed;
    logic signed [16:0] calibrated_speed;
    logic signed [15:0] gps_speed_out;
    logic               gps_used;
    logic               sensor_connected;

    modport source (output valid, true_speed, calibrated_speed, gps_speed_out,
                    gps_used, sensor_connected, input ready);
    modport sink (input valid, true_speed, calibrated_speed, gps_speed_out,
                  gps_used, sensor_connected, output ready);
endinterface
`default_nettype wire

// ===== design/airspeed_baro_gps_fusion_core.sv =====
// Airspeed fusion core: pressure-sensor airspeed corrected to true airspeed and
// blended with a GPS airspeed estimate.
// The sample channel carries one loop pass per beat; the result channel
// returns exactly one beat for every sample beat, in order.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data). The user
// must see that it is written only while no sample is in flight; the core does
// not enforce this. A sample is taken only when the core is idle. It then runs
// a small sequencer around one shared 36 x 20 multiplier, one restoring divider
// (50 quotient bits) and one square root unit. Which steps run depends on the
// path: neither filter, the baro low-pass, the bias correction, or GPS alone
// setting the speed.
// The next sample can be taken in the cycle after the result beat.
// The result beat is held until the receiver takes it; while it waits no new
// sample is taken.
// Reset clears the filter state and loads the default configuration; the core
// is ready for a sample as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module airspeed_baro_gps_fusion_core #(
    parameter int SPEED_FRAC_BITS = abgf_pkg::SPEED_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    abgf_in_if.sink          sample,
    abgf_out_if.source       result
);
    import abgf_pkg::*;

    localparam int ITERM_W = SPEED_FRAC_BITS + 4;

    logic        gps_only_reg;
    logic [15:0] period_reg, kp_reg, ki_reg, gps_tau_reg, baro_tau_reg, hold_reg;
    logic [10:0] offset_reg;

    state_t state_reg, state_next;

    logic signed [SPD_W-1:0]   tas_reg, tas_next, cas_reg, cas_next;
    logic signed [15:0]        gps_spd_reg, gps_spd_next;
    logic signed [ITERM_W-1:0] iterm_reg, iterm_next;
    logic                      pending_reg, pending_next;
    logic [16:0]               since_reg, since_next;

    logic [15:0]               dt_reg, dt_next, cas_in_reg, cas_in_next;
    logic signed [15:0]        gps_in_reg, gps_in_next;
    logic                      conn_reg, conn_next, used_reg, used_next;
    logic signed [BARO_W-1:0]  baro_reg, baro_next;
    logic [FAC_W-1:0]          fac_reg, fac_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic                      div_run_reg, div_run_next, div_neg_reg, div_neg_next;
    logic [DIV_CW-1:0]         div_cnt_reg, div_cnt_next;
    logic [DIV_NW-1:0]         div_num_reg, div_num_next;
    logic [DIV_DW:0]           div_rem_reg, div_rem_next;
    logic [DIV_DW-1:0]         div_den_reg, div_den_next;

    logic [SQ_W-1:0]           sq_x_reg, sq_x_next, sq_r_reg, sq_r_next;
    logic [SQ_W-1:0]           sq_bit_reg, sq_bit_next;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]   mul_p;

    logic                      is_div, div_done, consume, gps_pos;
    logic [16:0]               glp_den, blp_den;
    logic signed [MB_W-1:0]    err;
    logic [DIV_DW-1:0]         den_sel, half_sel;
    logic [ACC_W-1:0]          acc_mag;
    logic signed [DIV_NW:0]    div_q;
    logic [DIV_DW:0]           rem_sh;
    logic [SQ_W-1:0]           sq_t;
    logic signed [16:0]        tk;
    logic [17:0]               since_sum;
    logic [33:0]               baro_rnd;
    logic signed [WIDE_W-1:0]  it_sum, it_lim, kp_sum;
    logic [ACC_W-1:0]          kp_rnd;
    logic signed [SPD_W-1:0]   q_sat;

    assign glp_den  = {1'b0, period_reg} + {1'b0, gps_tau_reg};
    assign blp_den  = {1'b0, dt_reg} + {1'b0, baro_tau_reg};
    assign err      = MB_W'(gps_in_reg) - MB_W'(baro_reg);
    assign consume  = pending_reg && (gps_only_reg || (since_reg > {1'b0, hold_reg}));
    assign gps_pos  = gps_in_reg > 16'sd0;
    assign is_div   = (state_reg == ST_FAC_DIV) || (state_reg == ST_KI_DIV) ||
                      (state_reg == ST_GLP_DIV) || (state_reg == ST_CAS_DIV) ||
                      (state_reg == ST_BLP_DIV);
    assign div_done = is_div && div_run_reg && (div_cnt_reg == '0);
    assign mul_p    = ACC_W'(mul_a) * ACC_W'(mul_b);
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_q    = div_neg_reg ? -$signed({1'b0, div_num_reg}) : $signed({1'b0, div_num_reg});
    assign q_sat    = sat_speed(WIDE_W'(div_q));
    assign rem_sh   = {div_rem_reg[DIV_DW-1:0], div_num_reg[DIV_NW-1]};
    assign sq_t     = sq_r_reg + sq_bit_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_FAC_DIV:  den_sel = DIV_DW'(REF_KELVIN_CENTI);
            ST_KI_DIV:   den_sel = DIV_DW'(KI_DIVISOR);
            ST_GLP_DIV:  den_sel = DIV_DW'(glp_den);
            ST_CAS_DIV:  den_sel = DIV_DW'(fac_reg);
            ST_BLP_DIV:  den_sel = DIV_DW'(blp_den);
            default:     den_sel = DIV_DW'(1);
        endcase
        half_sel = (state_reg == ST_FAC_DIV) ? '0 : (den_sel >> 1);
    end

    always_comb
    begin
        unique case (state_reg)
            ST_BARO_MUL:
            begin
                mul_a = MA_W'($signed({1'b0, cas_in_reg}));
                mul_b = MB_W'($signed({1'b0, fac_reg}));
            end
            ST_KI_MUL1:
            begin
                mul_a = MA_W'($signed({1'b0, ki_reg}));
                mul_b = err;
            end
            ST_KI_MUL2:
            begin
                mul_a = acc_reg[MA_W-1:0];
                mul_b = MB_W'($signed({1'b0, dt_reg}));
            end
            ST_KP_MUL:
            begin
                mul_a = MA_W'($signed({1'b0, kp_reg}));
                mul_b = err;
            end
            ST_GLP_MUL1:
            begin
                mul_a = MA_W'(gps_in_reg);
                mul_b = MB_W'($signed({1'b0, period_reg}));
            end
            ST_GLP_MUL2:
            begin
                mul_a = MA_W'(tas_reg);
                mul_b = MB_W'($signed({1'b0, gps_tau_reg}));
            end
            ST_BLP_MUL1:
            begin
                mul_a = MA_W'(baro_reg);
                mul_b = MB_W'($signed({1'b0, dt_reg}));
            end
            ST_BLP_MUL2:
            begin
                mul_a = MA_W'(tas_reg);
                mul_b = MB_W'($signed({1'b0, baro_tau_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (sample.valid) state_next = ST_FAC_DIV;
            ST_FAC_DIV:  if (div_done) state_next = ST_FAC_SQRT;
            ST_FAC_SQRT: if (sq_bit_reg == '0) state_next = ST_BARO_MUL;
            ST_BARO_MUL: state_next = ST_BRANCH;
            ST_BRANCH:
            begin
                priority if (consume && gps_pos)
                begin
                    if (conn_reg)
                        state_next = ST_KI_MUL1;
                    else if (glp_den == '0)
                        state_next = ST_CAS_DIV;
                    else
                        state_next = ST_GLP_MUL1;
                end
                else if (conn_reg && (blp_den != '0))
                    state_next = ST_BLP_MUL1;
                else
                    state_next = ST_OUT;
            end
            ST_KI_MUL1:  state_next = ST_KI_MUL2;
            ST_KI_MUL2:  state_next = ST_KI_DIV;
            ST_KI_DIV:   if (div_done) state_next = ST_KP_MUL;
            ST_KP_MUL:   state_next = ST_KP_FIN;
            ST_KP_FIN:   state_next = ST_OUT;
            ST_GLP_MUL1: state_next = ST_GLP_MUL2;
            ST_GLP_MUL2: state_next = ST_GLP_DIV;
            ST_GLP_DIV:  if (div_done) state_next = ST_CAS_DIV;
            ST_CAS_DIV:  if (div_done) state_next = ST_OUT;
            ST_BLP_MUL1: state_next = ST_BLP_MUL2;
            ST_BLP_MUL2: state_next = ST_BLP_DIV;
            ST_BLP_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:      if (result.ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tas_next     = tas_reg;
        cas_next     = cas_reg;
        gps_spd_next = gps_spd_reg;
        iterm_next   = iterm_reg;
        pending_next = pending_reg;
        since_next   = since_reg;
        dt_next      = dt_reg;
        cas_in_next  = cas_in_reg;
        gps_in_next  = gps_in_reg;
        conn_next    = conn_reg;
        used_next    = used_reg;
        baro_next    = baro_reg;
        fac_next     = fac_reg;
        acc_next     = acc_reg;
        div_run_next = div_run_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;
        div_num_next = div_num_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        sq_x_next    = sq_x_reg;
        sq_r_next    = sq_r_reg;
        sq_bit_next  = sq_bit_reg;

        since_sum = {1'b0, since_reg} + {2'b0, sample.elapsed_ms};
        tk = 17'(sample.temperature_centi) - $signed({6'b0, offset_reg}) +
             17'sd27315;
        baro_rnd = acc_reg[33:0] + 34'd32768;
        it_sum = WIDE_W'(iterm_reg) + WIDE_W'(div_q);
        it_lim = WIDE_W'(signed'(5)) <<< SPEED_FRAC_BITS;
        kp_rnd = (acc_mag + ACC_W'(32768)) >> 16;
        kp_sum = WIDE_W'(baro_reg) +
                 (acc_reg[ACC_W-1] ? -WIDE_W'($signed({1'b0, kp_rnd}))
                                   : WIDE_W'($signed({1'b0, kp_rnd})));

        if (is_div)
        begin
            if (!div_run_reg)
            begin
                div_run_next = 1'b1;
                div_cnt_next = DIV_CW'(DIV_NW);
                div_num_next = acc_mag[DIV_NW-1:0] + DIV_NW'(half_sel);
                div_den_next = den_sel;
                div_neg_next = acc_reg[ACC_W-1];
                div_rem_next = '0;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_next = div_cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, div_den_reg})
                begin
                    div_rem_next = rem_sh - {1'b0, div_den_reg};
                    div_num_next = {div_num_reg[DIV_NW-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = rem_sh;
                    div_num_next = {div_num_reg[DIV_NW-2:0], 1'b0};
                end
            end
            else
            begin
                div_run_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    dt_next      = sample.elapsed_ms;
                    cas_in_next  = sample.cas_sensor;
                    gps_in_next  = sample.gps_speed_in;
                    conn_next    = sample.sensor_present && !gps_only_reg;
                    used_next    = 1'b0;
                    pending_next = pending_reg | sample.gps_ready;
                    since_next   = (since_sum > 18'(SINCE_MAX)) ? 17'(SINCE_MAX)
                                                               : since_sum[16:0];
                    acc_next     = (tk < 17'sd1) ? (ACC_W'(1) <<< 32)
                                                 : (ACC_W'(tk) <<< 32);
                end
            end
            ST_FAC_DIV:
            begin
                if (div_done)
                begin
                    sq_x_next   = div_num_reg[SQ_W-1:0];
                    sq_r_next   = '0;
                    sq_bit_next = SQ_W'(1) << 32;
                end
            end
            ST_FAC_SQRT:
            begin
                if (sq_bit_reg != '0)
                begin
                    if (sq_x_reg >= sq_t)
                    begin
                        sq_x_next = sq_x_reg - sq_t;
                        sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_next = sq_r_reg >> 1;
                    end
                    sq_bit_next = sq_bit_reg >> 2;
                end
                else
                begin
                    fac_next = (sq_r_reg == '0) ? FAC_W'(1) : sq_r_reg[FAC_W-1:0];
                end
            end
            ST_BARO_MUL:
            begin
                acc_next = mul_p;
            end
            ST_BRANCH:
            begin
                baro_next = gps_only_reg ? '0 :
                            ($signed({1'b0, baro_rnd[33:16]}) + BARO_W'(iterm_reg));
                if (conn_reg)
                    cas_next = $signed({1'b0, cas_in_reg});
                if (consume)
                begin
                    pending_next = 1'b0;
                    since_next   = '0;
                    used_next    = gps_pos;
                    if (gps_pos)
                    begin
                        gps_spd_next = gps_in_reg;
                        if (!conn_reg && (glp_den == '0))
                        begin
                            tas_next = SPD_W'(gps_in_reg);
                            acc_next = ACC_W'(gps_in_reg) <<< 16;
                        end
                    end
                end
            end
            ST_KI_MUL1, ST_KI_MUL2, ST_KP_MUL, ST_GLP_MUL1, ST_BLP_MUL1:
            begin
                acc_next = mul_p;
            end
            ST_GLP_MUL2, ST_BLP_MUL2:
            begin
                acc_next = acc_reg + mul_p;
            end
            ST_KI_DIV:
            begin
                if (div_done)
                begin
                    if (it_sum > it_lim)
                        iterm_next = ITERM_W'(it_lim);
                    else if (it_sum < -it_lim)
                        iterm_next = ITERM_W'(-it_lim);
                    else
                        iterm_next = ITERM_W'(it_sum);
                end
            end
            ST_KP_FIN:
            begin
                tas_next = sat_speed(kp_sum);
            end
            ST_GLP_DIV:
            begin
                if (div_done)
                begin
                    tas_next = q_sat;
                    acc_next = ACC_W'(q_sat) <<< 16;
                end
            end
            ST_CAS_DIV:
            begin
                if (div_done)
                    cas_next = q_sat;
            end
            ST_BLP_DIV:
            begin
                if (div_done)
                    tas_next = q_sat;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_only_reg <= 1'b0;
            period_reg   <= RST_PERIOD;
            kp_reg       <= RST_KP;
            ki_reg       <= RST_KI;
            gps_tau_reg  <= RST_GPS_TAU;
            baro_tau_reg <= RST_BARO_TAU;
            hold_reg     <= RST_HOLD;
            offset_reg   <= RST_OFFSET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GPS_ONLY: gps_only_reg <= cfg_data[0];
                CFG_PERIOD:   period_reg   <= cfg_data;
                CFG_KP:       kp_reg       <= cfg_data;
                CFG_KI:       ki_reg       <= cfg_data;
                CFG_GPS_TAU:  gps_tau_reg  <= cfg_data;
                CFG_BARO_TAU: baro_tau_reg <= cfg_data;
                CFG_HOLD:     hold_reg     <= cfg_data;
                CFG_OFFSET:   offset_reg   <= cfg_data[10:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tas_reg     <= '0;
            cas_reg     <= '0;
            gps_spd_reg <= '0;
            iterm_reg   <= '0;
            pending_reg <= 1'b0;
            since_reg   <= '0;
            div_run_reg <= 1'b0;
            div_cnt_reg <= '0;
            sq_bit_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tas_reg     <= tas_next;
            cas_reg     <= cas_next;
            gps_spd_reg <= gps_spd_next;
            iterm_reg   <= iterm_next;
            pending_reg <= pending_next;
            since_reg   <= since_next;
            div_run_reg <= div_run_next;
            div_cnt_reg <= div_cnt_next;
            sq_bit_reg  <= sq_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg      <= dt_next;
        cas_in_reg  <= cas_in_next;
        gps_in_reg  <= gps_in_next;
        conn_reg    <= conn_next;
        used_reg    <= used_next;
        baro_reg    <= baro_next;
        fac_reg     <= fac_next;
        acc_reg     <= acc_next;
        div_neg_reg <= div_neg_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        sq_x_reg    <= sq_x_next;
        sq_r_reg    <= sq_r_next;
    end

    assign sample.ready            = (state_reg == ST_IDLE);
    assign result.valid            = (state_reg == ST_OUT);
    assign result.true_speed       = tas_reg;
    assign result.calibrated_speed = cas_reg;
    assign result.gps_speed_out    = gps_spd_reg;
    assign result.gps_used         = used_reg;
    assign result.sensor_connected = conn_reg;

endmodule
`default_nettype wire

// ===== sim/airspeed_baro_gps_fusion_core_tb.sv =====
`timescale 1ns / 1ps
module airspeed_baro_gps_fusion_core_tb;
    import abgf_pkg::*;

    typedef struct {
        logic        [15:0] dt;
        logic        [15:0] cas;
        logic               present;
        logic signed [14:0] temp;
        logic               fresh;
        logic signed [15:0] gps;
    } loop_pass_t;

    typedef struct {
        logic signed [16:0] tas;
        logic signed [16:0] cas;
        logic signed [15:0] gps;
        logic               used;
        logic               conn;
    } airspeed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    abgf_in_if  sample ();
    abgf_out_if result ();

    airspeed_baro_gps_fusion_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample.sink),
        .result    (result.source)
    );

    always #5 clk = ~clk;

    loop_pass_t pass_queue[$];
    airspeed_t  expected_speeds[$];
    int         fail_count = 0;
    bit         quiet = 1'b0;
    bit         long_hold_req = 1'b0;
    int         send_gap = 0;
    int         recv_hold = 0;

    // Shadow configuration and filter state.
    longint m_gps_only, m_period, m_kp, m_ki, m_gps_tau, m_baro_tau, m_hold, m_offset;
    longint s_tas, s_cas, s_gps, s_iterm, s_since;
    bit     s_pending;

    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        if (d <= 0)
            return 0;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp_speed(longint v);
        if (v > 65535)
            return 65535;
        if (v < -65536)
            return -65536;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic airspeed_t fuse_pass(loop_pass_t p);
        airspeed_t r;
        longint dt, cas_in, temp, gps, tk, fac, baro, since, err, it, den, lim;
        bit gonly, conn, consume, valid;
        dt = longint'(p.dt);
        cas_in = longint'(p.cas);
        temp = longint'(p.temp);
        gps = longint'(p.gps);
        gonly = (m_gps_only != 0);
        conn = p.present && !gonly;
        valid = 1'b0;
        baro = 0;
        lim = 5 << 8;
        if (p.fresh)
            s_pending = 1'b1;
        since = s_since + dt;
        s_since = (since > SINCE_MAX) ? SINCE_MAX : since;
        tk = temp - m_offset + KELVIN_CENTI;
        if (tk < 1)
            tk = 1;
        fac = int_sqrt((longint'(tk) << 32) / REF_KELVIN_CENTI);
        if (fac < 1)
            fac = 1;
        if (!gonly)
            baro = ((cas_in * fac + 32768) >>> 16) + s_iterm;
        if (conn)
            s_cas = cas_in;
        consume = s_pending && (gonly || s_since > m_hold);
        if (consume)
        begin
            s_pending = 1'b0;
            s_since = 0;
            valid = (gps > 0);
        end
        if (valid)
        begin
            s_gps = gps;
            if (conn)
            begin
                err = gps - baro;
                it = s_iterm + round_div(m_ki * err * dt, KI_DIVISOR);
                if (it > lim)
                    it = lim;
                if (it < -lim)
                    it = -lim;
                s_iterm = it;
                s_tas = clamp_speed(baro + round_div(m_kp * err, 65536));
            end
            else
            begin
                den = m_period + m_gps_tau;
                if (den == 0)
                    s_tas = clamp_speed(gps);
                else
                    s_tas = clamp_speed(round_div(gps * m_period + s_tas * m_gps_tau, den));
                s_cas = clamp_speed(round_div(s_tas * 65536, fac));
            end
        end
        else if (conn)
        begin
            den = dt + m_baro_tau;
            if (den != 0)
                s_tas = clamp_speed(round_div(baro * dt + s_tas * m_baro_tau, den));
        end
        r.tas = s_tas[16:0];
        r.cas = s_cas[16:0];
        r.gps = s_gps[15:0];
        r.used = valid;
        r.conn = conn;
        return r;
    endfunction

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        loop_pass_t p;
        loop_pass_t q;
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            sample.elapsed_ms <= '0;
            sample.cas_sensor <= '0;
            sample.sensor_present <= 1'b0;
            sample.temperature_centi <= '0;
            sample.gps_ready <= 1'b0;
            sample.gps_speed_in <= '0;
        end
        else if (!(sample.valid && !sample.ready))
        begin
            if (sample.valid)
            begin
                p.dt = sample.elapsed_ms;
                p.cas = sample.cas_sensor;
                p.present = sample.sensor_present;
                p.temp = sample.temperature_centi;
                p.fresh = sample.gps_ready;
                p.gps = sample.gps_speed_in;
                expected_speeds.push_back(fuse_pass(p));
            end
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                sample.valid <= 1'b0;
            end
            else if (!quiet && pass_queue.size() > 0 && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(1, 17) - 1;
                sample.valid <= 1'b0;
            end
            else if (pass_queue.size() > 0)
            begin
                q = pass_queue.pop_front();
                sample.elapsed_ms <= q.dt;
                sample.cas_sensor <= q.cas;
                sample.sensor_present <= q.present;
                sample.temperature_centi <= q.temp;
                sample.gps_ready <= q.fresh;
                sample.gps_speed_in <= q.gps;
                sample.valid <= 1'b1;
            end
            else
            begin
                sample.valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        airspeed_t e;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_speeds.pop_front();
                    if (result.true_speed !== e.tas)
                    begin
                        $error("true_speed: expected %0d, got %0d", e.tas, result.true_speed);
                        fail_count++;
                    end
                    if (result.calibrated_speed !== e.cas)
                    begin
                        $error("calibrated_speed: expected %0d, got %0d", e.cas,
                               result.calibrated_speed);
                        fail_count++;
                    end
                    if (result.gps_speed_out !== e.gps)
                    begin
                        $error("gps_speed_out: expected %0d, got %0d", e.gps,
                               result.gps_speed_out);
                        fail_count++;
                    end
                    if (result.gps_used !== e.used)
                    begin
                        $error("gps_used: expected %0d, got %0d", e.used, result.gps_used);
                        fail_count++;
                    end
                    if (result.sensor_connected !== e.conn)
                    begin
                        $error("sensor_connected: expected %0d, got %0d", e.conn,
                               result.sensor_connected);
                        fail_count++;
                    end
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_hold = 1500;
                result.ready <= 1'b0;
            end
            else if (recv_hold > 0)
            begin
                recv_hold = recv_hold - 1;
                result.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_hold = $urandom_range(1, 17) - 1;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    task automatic add_pass(int dt, int cas, bit pr, int temp, bit fresh, int gps);
        loop_pass_t p;
        p.dt = dt[15:0];
        p.cas = cas[15:0];
        p.present = pr;
        p.temp = temp[14:0];
        p.fresh = fresh;
        p.gps = gps[15:0];
        pass_queue.push_back(p);
    endtask

    task automatic add_random_passes(int n);
        int dt, cas, gps, temp;
        for (int i = 0; i < n; i++)
        begin
            dt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
            cas = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 15000);
            temp = $urandom_range(0, 17000) - 5000;
            case ($urandom_range(0, 9))
                0, 1: gps = $urandom_range(0, 65535) - 32768;
                2: gps = 0;
                default: gps = $urandom_range(1, 32767);
            endcase
            add_pass(dt, cas, $urandom_range(0, 7) != 0, temp, $urandom_range(0, 2) == 0, gps);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        case (idx)
            CFG_GPS_ONLY: m_gps_only = val & 1;
            CFG_PERIOD:   m_period = val & 16'hFFFF;
            CFG_KP:       m_kp = val & 16'hFFFF;
            CFG_KI:       m_ki = val & 16'hFFFF;
            CFG_GPS_TAU:  m_gps_tau = val & 16'hFFFF;
            CFG_BARO_TAU: m_baro_tau = val & 16'hFFFF;
            CFG_HOLD:     m_hold = val & 16'hFFFF;
            CFG_OFFSET:   m_offset = val & 11'h7FF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(int gonly, int per, int kp, int ki, int gtau, int btau, int hold,
                           int offs);
        write_reg(CFG_GPS_ONLY, gonly);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_GPS_TAU, gtau);
        write_reg(CFG_BARO_TAU, btau);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_OFFSET, offs);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pass_queue.size() != 0 || sample.valid || expected_speeds.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        m_gps_only = 0; m_period = RST_PERIOD; m_kp = RST_KP; m_ki = RST_KI;
        m_gps_tau = RST_GPS_TAU; m_baro_tau = RST_BARO_TAU; m_hold = RST_HOLD;
        m_offset = RST_OFFSET;
        s_tas = 0; s_cas = 0; s_gps = 0; s_iterm = 0; s_since = 0; s_pending = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_pass(0, 0, 1, -5000, 0, 0);
        add_pass(65535, 65535, 1, 12000, 0, 0);
        add_pass(100, 5000, 1, 2000, 1, 4000);
        add_pass(2000, 5000, 1, 2000, 0, 0);
        add_pass(2000, 5000, 1, 2000, 1, 32767);
        add_pass(2000, 65535, 1, -5000, 1, -32768);
        add_pass(2000, 4000, 1, 2500, 1, 0);
        add_pass(65535, 0, 1, 12000, 1, 32767);
        add_pass(1500, 6000, 0, 1500, 1, 6500);
        add_pass(1500, 6000, 0, 1500, 0, 100);
        add_pass(1500, 6000, 0, 1500, 1, -1);
        add_pass(300, 7000, 1, 2000, 1, 7100);
        add_pass(800, 7000, 1, 2000, 0, 9000);
        add_pass(65535, 65535, 1, -1, 1, 1);
        add_pass(0, 1, 1, 0, 0, 0);
        wait_drained();

        add_random_passes(470);
        wait_drained();

        set_all(1, 0, 0, 0, 0, 1, 0, 2000);
        add_pass(10, 3000, 1, -5000, 1, 5000);
        add_pass(0, 3000, 1, 12000, 1, 32767);
        add_pass(0, 3000, 1, 0, 1, 0);
        add_random_passes(300);
        wait_drained();

        set_all(0, 65535, 65535, 65535, 65535, 1, 0, 0);
        long_hold_req = 1'b1;
        add_random_passes(480);
        wait_drained();

        set_all(0, 200, 0, 0, 65535, 65535, 65535, 1234);
        add_random_passes(200);
        wait_drained();

        set_all(0, 1000, 30000, 20000, 500, 300, 200, 500);
        quiet = 1'b1;
        add_random_passes(450);
        wait_drained();

        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("airspeed_baro_gps_fusion_core_tb OK");
        else
            $display("airspeed_baro_gps_fusion_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("airspeed_baro_gps_fusion_core_tb NOT OK");
        $finish;
    end
endmodule

// ===== airspeed_baro_gps_fusion_core.f =====
design/abgf_pkg.sv
design/abgf_in_if.sv
design/abgf_out_if.sv
design/airspeed_baro_gps_fusion_core.sv
sim/airspeed_baro_gps_fusion_core_tb.sv
